FILE: src/ppdu_pkg.sv
// ----------------------------------------------------------------------------
// ppdu_pkg
// shared types, codes and sizes of the priority periodic task dispatcher
// ----------------------------------------------------------------------------
package ppdu_pkg;

  localparam int MaxTasks = 16;
  localparam int SlotBits = $clog2(MaxTasks);
  localparam int TimeBits = 32;
  localparam int PrioBits = 8;
  localparam int AgeBits  = 32;

  // opcodes
  localparam logic [1:0] OP_POLL   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  // slot states
  localparam logic [1:0] ST_STARTED   = 2'd0;
  localparam logic [1:0] ST_STOPPED   = 2'd1;
  localparam logic [1:0] ST_SUSPENDED = 2'd2;
  localparam logic [1:0] ST_RUNNING   = 2'd3;

  // result codes
  localparam logic [2:0] RES_OK         = 3'd0;
  localparam logic [2:0] RES_FULL       = 3'd1;
  localparam logic [2:0] RES_NO_TASK    = 3'd2;
  localparam logic [2:0] RES_NONE_READY = 3'd3;
  localparam logic [2:0] RES_BUSY       = 3'd4;

  typedef struct packed {
    logic [1:0]          state;
    logic [PrioBits-1:0] prio;
    logic [TimeBits-1:0] period;
    logic [TimeBits-1:0] suspend;
    logic [TimeBits-1:0] start_time;
    logic [AgeBits-1:0]  age;
  } slot_rec_t;

  localparam int RecBits = $bits(slot_rec_t);

  // started task waits for its period, suspended task for its suspend interval
  function automatic logic slot_ready(slot_rec_t rec, logic [TimeBits-1:0] now);
    logic [TimeBits-1:0] elapsed;
    logic                rdy;
    elapsed = now - rec.start_time;
    rdy     = 1'b0;
    if (rec.state == ST_STARTED) begin
      rdy = (elapsed >= rec.period);
    end else if (rec.state == ST_SUSPENDED) begin
      rdy = (elapsed >= rec.suspend);
    end
    return rdy;
  endfunction

endpackage

FILE: src/ppdu_ram.sv
// ----------------------------------------------------------------------------
// ppdu_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ppdu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/priority_periodic_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// priority_periodic_task_dispatcher_unit
// task table with priority dispatch of periodic and suspended tasks
// ----------------------------------------------------------------------------
// usage:
// - input channel (in_valid_i / in_stall_o) carries one command beat: poll,
//   add, remove or finish. every command gives exactly one result beat on the
//   output channel (out_valid_o / out_stall_i).
// - task records live in one ram with registered read; slot valid bits, the
//   running marker and the add counter sit in flip-flops.
// - add, remove and a rejected command go from accept straight to the
//   result state. finish reads the slot then writes it back.
// - poll scans the table one slot a cycle through the ram read port, then
//   writes the winner back, if one is found. a poll while a task runs
//   answers busy.
// - one command is in flight at a time: in_stall_o is high from accept until
//   the result has been moved to the output register.
// - a result waits in the output register while out_stall_i is high; the
//   block then holds its finished result and stalls the input.
// - reset empties the table and clears the running marker and add counter;
//   the ram itself needs no clearing since free slots are never evaluated.
// ----------------------------------------------------------------------------
module priority_periodic_task_dispatcher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] now_time_i,
  input  logic [3:0]  task_handle_i,
  input  logic [7:0]  task_priority_i,
  input  logic [31:0] task_period_i,
  input  logic [1:0]  next_state_i,
  input  logic [31:0] suspend_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        dispatched_o,
  output logic [3:0]  result_handle_o,
  output logic [2:0]  status_o
);

  localparam int SlotBits = ppdu_pkg::SlotBits;
  localparam int TimeBits = ppdu_pkg::TimeBits;
  localparam int AgeBits  = ppdu_pkg::AgeBits;

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_POLL_WR = 3'd2;
  localparam logic [2:0] S_FIN_WR  = 3'd3;
  localparam logic [2:0] S_RESP    = 3'd4;

  logic [2:0] state_q, state_d;

  // control state
  logic [ppdu_pkg::MaxTasks-1:0] valid_q, valid_d;
  logic                          running_q, running_d;
  logic [SlotBits-1:0]           run_slot_q, run_slot_d;
  logic [AgeBits-1:0]            add_cnt_q, add_cnt_d;
  logic [SlotBits-1:0]           scan_q, scan_d;
  logic                          found_q, found_d;
  logic                          out_valid_q, out_valid_d;

  // payload registers
  logic [TimeBits-1:0]     now_q, now_d;
  logic [SlotBits-1:0]     handle_q, handle_d;
  logic [1:0]              nstate_q, nstate_d;
  logic [TimeBits-1:0]     susp_q, susp_d;
  logic [SlotBits-1:0]     best_idx_q, best_idx_d;
  ppdu_pkg::slot_rec_t     best_rec_q, best_rec_d;
  logic                    res_disp_q, res_disp_d;
  logic [3:0]              res_handle_q, res_handle_d;
  logic [2:0]              res_status_q, res_status_d;
  logic                    out_disp_q, out_disp_d;
  logic [3:0]              out_handle_q, out_handle_d;
  logic [2:0]              out_status_q, out_status_d;

  // ram ports
  logic                         ram_we;
  logic [SlotBits-1:0]          ram_waddr;
  ppdu_pkg::slot_rec_t          ram_wrec;
  logic [SlotBits-1:0]          ram_raddr;
  logic [ppdu_pkg::RecBits-1:0] ram_rdata;
  ppdu_pkg::slot_rec_t          rd_rec;

  // lowest free slot
  logic                free_any;
  logic [SlotBits-1:0] free_idx;

  logic in_acc;
  logic cand;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd_rec     = ppdu_pkg::slot_rec_t'(ram_rdata);

  ppdu_ram #(
    .Width (ppdu_pkg::RecBits),
    .Depth (ppdu_pkg::MaxTasks)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wrec),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ppdu_pkg::MaxTasks - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SlotBits'(i);
      end
    end
  end

  // valid, ready slot under scan beats the best so far: higher priority, or older on a tie
  always_comb begin
    cand = valid_q[scan_q] && ppdu_pkg::slot_ready(rd_rec, now_q) &&
           (!found_q || (rd_rec.prio > best_rec_q.prio) ||
            ((rd_rec.prio == best_rec_q.prio) && (rd_rec.age < best_rec_q.age)));
  end

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    running_d    = running_q;
    run_slot_d   = run_slot_q;
    add_cnt_d    = add_cnt_q;
    scan_d       = scan_q;
    found_d      = found_q;
    now_d        = now_q;
    handle_d     = handle_q;
    nstate_d     = nstate_q;
    susp_d       = susp_q;
    best_idx_d   = best_idx_q;
    best_rec_d   = best_rec_q;
    res_disp_d   = res_disp_q;
    res_handle_d = res_handle_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = task_handle_i;
    ram_wrec     = rd_rec;
    ram_raddr    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          now_d        = now_time_i;
          handle_d     = task_handle_i;
          nstate_d     = next_state_i;
          susp_d       = suspend_time_i;
          res_disp_d   = 1'b0;
          res_handle_d = task_handle_i;
          res_status_d = ppdu_pkg::RES_OK;
          state_d      = S_RESP;
          case (opcode_i)
            ppdu_pkg::OP_POLL: begin
              res_handle_d = '0;
              if (running_q) begin
                res_status_d = ppdu_pkg::RES_BUSY;
              end else begin
                // slot 0 address goes out now, its record arrives next cycle
                ram_raddr = '0;
                scan_d    = '0;
                found_d   = 1'b0;
                state_d   = S_SCAN;
              end
            end
            ppdu_pkg::OP_ADD: begin
              if (free_any) begin
                ram_we              = 1'b1;
                ram_waddr           = free_idx;
                ram_wrec.state      = ppdu_pkg::ST_STARTED;
                ram_wrec.prio       = task_priority_i;
                ram_wrec.period     = task_period_i;
                ram_wrec.suspend    = '0;
                ram_wrec.start_time = '0;
                ram_wrec.age        = add_cnt_q;
                valid_d[free_idx]   = 1'b1;
                add_cnt_d           = add_cnt_q + AgeBits'(1);
                res_handle_d        = free_idx;
              end else begin
                res_handle_d = '0;
                res_status_d = ppdu_pkg::RES_FULL;
              end
            end
            ppdu_pkg::OP_REMOVE: begin
              if (!valid_q[task_handle_i]) begin
                res_status_d = ppdu_pkg::RES_NO_TASK;
              end else begin
                valid_d[task_handle_i] = 1'b0;
                if (running_q && (run_slot_q == task_handle_i)) begin
                  running_d = 1'b0;
                end
              end
            end
            ppdu_pkg::OP_FINISH: begin
              if (!valid_q[task_handle_i]) begin
                res_status_d = ppdu_pkg::RES_NO_TASK;
              end else if (!running_q || (run_slot_q != task_handle_i) ||
                           (next_state_i == ppdu_pkg::ST_RUNNING)) begin
                res_status_d = ppdu_pkg::RES_BUSY;
              end else begin
                // fetch the record, patch it next cycle
                ram_raddr = task_handle_i;
                state_d   = S_FIN_WR;
              end
            end
            default: begin
              res_status_d = ppdu_pkg::RES_BUSY;
            end
          endcase
        end
      end

      S_SCAN: begin
        ram_raddr = scan_q + SlotBits'(1);
        if (cand) begin
          found_d    = 1'b1;
          best_idx_d = scan_q;
          best_rec_d = rd_rec;
        end
        scan_d = scan_q + SlotBits'(1);
        if (scan_q == SlotBits'(ppdu_pkg::MaxTasks - 1)) begin
          state_d = S_POLL_WR;
        end
      end

      S_POLL_WR: begin
        if (found_q) begin
          ram_we              = 1'b1;
          ram_waddr           = best_idx_q;
          ram_wrec            = best_rec_q;
          ram_wrec.state      = ppdu_pkg::ST_RUNNING;
          ram_wrec.start_time = now_q;
          running_d           = 1'b1;
          run_slot_d          = best_idx_q;
          res_disp_d          = 1'b1;
          res_handle_d        = best_idx_q;
          res_status_d        = ppdu_pkg::RES_OK;
        end else begin
          res_disp_d   = 1'b0;
          res_handle_d = '0;
          res_status_d = ppdu_pkg::RES_NONE_READY;
        end
        state_d = S_RESP;
      end

      S_FIN_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = handle_q;
        ram_wrec       = rd_rec;
        ram_wrec.state = nstate_q;
        if (nstate_q == ppdu_pkg::ST_SUSPENDED) begin
          ram_wrec.suspend = susp_q;
        end
        running_d = 1'b0;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register: loaded from the result when free or being taken
  always_comb begin
    out_valid_d  = out_valid_q;
    out_disp_d   = out_disp_q;
    out_handle_d = out_handle_q;
    out_status_d = out_status_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_RESP) && (!out_valid_q || !out_stall_i)) begin
      out_valid_d  = 1'b1;
      out_disp_d   = res_disp_q;
      out_handle_d = res_handle_q;
      out_status_d = res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      running_q   <= 1'b0;
      run_slot_q  <= '0;
      add_cnt_q   <= '0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      running_q   <= running_d;
      run_slot_q  <= run_slot_d;
      add_cnt_q   <= add_cnt_d;
      scan_q      <= scan_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    handle_q     <= handle_d;
    nstate_q     <= nstate_d;
    susp_q       <= susp_d;
    best_idx_q   <= best_idx_d;
    best_rec_q   <= best_rec_d;
    res_disp_q   <= res_disp_d;
    res_handle_q <= res_handle_d;
    res_status_q <= res_status_d;
    out_disp_q   <= out_disp_d;
    out_handle_q <= out_handle_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign dispatched_o    = out_disp_q;
  assign result_handle_o = out_handle_q;
  assign status_o        = out_status_q;

endmodule
